@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the frame receiver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/ifrd_pkg.sv @@
// Types, codes and reset values shared by the frame receiver modules
`default_nettype none

package ifrd_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_FLAG  = 3'd1,
      PH_ADDR  = 3'd2,
      PH_CTRL  = 3'd3,
      PH_DATA  = 3'd4,
      PH_ESC   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_NEW       = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_CHECK_ERR = 2'd2,
      ST_ABORT     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RP_NONE = 2'd0,
      RP_RR   = 2'd1,
      RP_REJ  = 2'd2
   } reply_code_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_REPORT  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      REG_FLAG     = 3'd0,
      REG_ESCAPE   = 3'd1,
      REG_ESC_FLAG = 3'd2,
      REG_ESC_ESC  = 3'd3,
      REG_ADDRESS  = 3'd4,
      REG_CTRL0    = 3'd5,
      REG_CTRL1    = 3'd6
   } reg_index_type;

   localparam logic [7:0] FLAG_RESET     = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET   = 8'h7D;
   localparam logic [7:0] ESC_FLAG_RESET = 8'h5E;
   localparam logic [7:0] ESC_ESC_RESET  = 8'h5D;
   localparam logic [7:0] ADDRESS_RESET  = 8'h03;
   localparam logic [7:0] CTRL0_RESET    = 8'h00;
   localparam logic [7:0] CTRL1_RESET    = 8'h40;

   localparam int        CSR_ADDR_W = 5;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_byte;
      logic [7:0] escaped_flag_code;
      logic [7:0] escaped_escape_code;
      logic [7:0] address_byte;
      logic [7:0] control_seq0;
      logic [7:0] control_seq1;
   } cfg_type;

   typedef struct packed {
      kind_type       out_kind;
      logic [15:0]    payload_length;
      logic           reply_seq;
      reply_code_type reply_type;
      status_type     frame_status;
      logic [7:0]     payload_byte;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/info_frame_receiver_destuff.sv @@
// Top level of the byte-stuffed information frame receiver
//
//   channel | direction | ports         | carries
//   --------+-----------+---------------+-----------------------------------
//   req     | in        | req_t*        | one raw line byte per word
//   rsp     | out       | rsp_t*        | payload byte or end-of-frame report
//   csr     | in/out    | csr_p*        | seven 8-bit registers at 4*i
//
// One word is taken per cycle while req_tready is high; the single parser step
// registers any result in the output register, or the skid stage on a stall.
// A skid stage holds one more result, so req_tready drops only when both the
// output register and the skid stage are full under a stalled rsp_tready.
// Reset is synchronous and returns the parser to waiting for a flag with
// registers at their defaults; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module info_frame_receiver_destuff
   import ifrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] payload_byte, [9:8] frame_status, [11:10] reply_type,
   // [12] reply_seq, [28:13] payload_length, [31:29] zero
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tuser,  // [0] out_kind
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type      cfg;
   logic         accept;
   logic         push;
   rsp_word_type push_word;
   rsp_word_type out_word;
   logic         skid_full;

   assign accept = req_tvalid & req_tready;

   ifrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ifrd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .cfg     (cfg),
      .push    (push),
      .word    (push_word)
   );

   ifrd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .in_ready  (req_tready),
      .skid_full (skid_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tuser = out_word.out_kind;
   assign rsp_tdata = {3'd0, out_word.payload_length, out_word.reply_seq,
                       out_word.reply_type, out_word.frame_status,
                       out_word.payload_byte};

   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_full, rsp_tvalid,
      "skid stage full while output register empty")
   `ASSERT_IMPLY(a_payload_clean, clock, reset,
      rsp_tvalid && out_word.out_kind == KIND_PAYLOAD,
      out_word.frame_status == ST_NEW && out_word.reply_type == RP_NONE &&
      out_word.payload_length == 16'd0,
      "payload word carries report fields")
   `ASSERT_IMPLY(a_new_frame_rr, clock, reset,
      rsp_tvalid && out_word.out_kind == KIND_REPORT && out_word.frame_status == ST_NEW,
      out_word.reply_type == RP_RR && out_word.payload_length != 16'd0,
      "accepted frame report without RR or length")
   `ASSERT_IMPLY(a_abort_silent, clock, reset,
      rsp_tvalid && out_word.out_kind == KIND_REPORT && out_word.frame_status == ST_ABORT,
      out_word.reply_type == RP_NONE && out_word.reply_seq == 1'b0,
      "abort report carries a reply")

endmodule

`default_nettype wire

@@ rtl/ifrd_csr.sv @@
// Configuration register file on the APB-style port
`default_nettype none

module ifrd_csr
   import ifrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_FLAG:     cfg_in.flag_byte           = pwdata[7:0];
            REG_ESCAPE:   cfg_in.escape_byte         = pwdata[7:0];
            REG_ESC_FLAG: cfg_in.escaped_flag_code   = pwdata[7:0];
            REG_ESC_ESC:  cfg_in.escaped_escape_code = pwdata[7:0];
            REG_ADDRESS:  cfg_in.address_byte        = pwdata[7:0];
            REG_CTRL0:    cfg_in.control_seq0        = pwdata[7:0];
            REG_CTRL1:    cfg_in.control_seq1        = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FLAG:     prdata = {24'd0, cfg_ff.flag_byte};
         REG_ESCAPE:   prdata = {24'd0, cfg_ff.escape_byte};
         REG_ESC_FLAG: prdata = {24'd0, cfg_ff.escaped_flag_code};
         REG_ESC_ESC:  prdata = {24'd0, cfg_ff.escaped_escape_code};
         REG_ADDRESS:  prdata = {24'd0, cfg_ff.address_byte};
         REG_CTRL0:    prdata = {24'd0, cfg_ff.control_seq0};
         REG_CTRL1:    prdata = {24'd0, cfg_ff.control_seq1};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte           <= FLAG_RESET;
         cfg_ff.escape_byte         <= ESCAPE_RESET;
         cfg_ff.escaped_flag_code   <= ESC_FLAG_RESET;
         cfg_ff.escaped_escape_code <= ESC_ESC_RESET;
         cfg_ff.address_byte        <= ADDRESS_RESET;
         cfg_ff.control_seq0        <= CTRL0_RESET;
         cfg_ff.control_seq1        <= CTRL1_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/ifrd_core.sv @@
// Frame parser: header match, destuffing, data check and sequence tracking
`default_nettype none

module ifrd_core
   import ifrd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output logic            push,
   output rsp_word_type    word
);

   phase_type   phase_ff, phase_in;
   logic        frame_seq_ff, frame_seq_in;
   logic [7:0]  data_xor_ff, data_xor_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic        expected_seq_ff, expected_seq_in;

   logic        is_flag, is_esc, is_code_flag, is_code_esc;
   logic [7:0]  hdr_check;
   logic        take;
   logic [7:0]  take_byte;

   assign is_flag      = (rx_byte == cfg.flag_byte);
   assign is_esc       = (rx_byte == cfg.escape_byte);
   assign is_code_flag = (rx_byte == cfg.escaped_flag_code);
   assign is_code_esc  = (rx_byte == cfg.escaped_escape_code);
   assign hdr_check    = cfg.address_byte ^
                         (frame_seq_ff ? cfg.control_seq1 : cfg.control_seq0);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_FLAG: begin
               if (rx_byte == cfg.address_byte) phase_in = PH_ADDR;
               else if (!is_flag)               phase_in = PH_START;
            end
            PH_ADDR: begin
               if (rx_byte == cfg.control_seq0 || rx_byte == cfg.control_seq1) begin
                  phase_in = PH_CTRL;
               end else if (is_flag) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_START;
               end
            end
            PH_CTRL: begin
               if (rx_byte == hdr_check) phase_in = PH_DATA;
               else if (is_flag)         phase_in = PH_FLAG;
               else                      phase_in = PH_START;
            end
            PH_DATA: begin
               if (is_flag)     phase_in = PH_START;
               else if (is_esc) phase_in = PH_ESC;
            end
            PH_ESC: begin
               if (is_code_flag || is_code_esc) phase_in = PH_DATA;
               else                             phase_in = PH_START;
            end
            default: phase_in = is_flag ? PH_FLAG : PH_START;
         endcase
      end
   end

   // Datapath and result word
   always_comb begin
      frame_seq_in    = frame_seq_ff;
      data_xor_in     = data_xor_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      byte_count_in   = byte_count_ff;
      expected_seq_in = expected_seq_ff;
      push            = 1'b0;
      word            = '0;
      take            = 1'b0;
      take_byte       = rx_byte;

      if (accept) begin
         case (phase_ff)
            PH_ADDR: begin
               if (rx_byte == cfg.control_seq0)      frame_seq_in = 1'b0;
               else if (rx_byte == cfg.control_seq1) frame_seq_in = 1'b1;
            end
            PH_CTRL: begin
               if (rx_byte == hdr_check) begin
                  data_xor_in   = 8'd0;
                  held_byte_in  = 8'd0;
                  held_valid_in = 1'b0;
                  byte_count_in = 16'd0;
               end
            end
            PH_DATA: begin
               if (is_flag) begin
                  push          = 1'b1;
                  word.out_kind = KIND_REPORT;
                  if (byte_count_ff == 16'd0 || data_xor_ff != 8'd0) begin
                     word.frame_status = ST_CHECK_ERR;
                     word.reply_type   = RP_REJ;
                     word.reply_seq    = frame_seq_ff;
                  end else if (frame_seq_ff == expected_seq_ff) begin
                     expected_seq_in     = ~expected_seq_ff;
                     word.frame_status   = ST_NEW;
                     word.reply_type     = RP_RR;
                     word.reply_seq      = ~frame_seq_ff;
                     word.payload_length = byte_count_ff;
                  end else begin
                     word.frame_status = ST_DUPLICATE;
                     word.reply_type   = RP_RR;
                     word.reply_seq    = ~frame_seq_ff;
                  end
               end else if (!is_esc) begin
                  take = 1'b1;
               end
            end
            PH_ESC: begin
               if (is_code_flag) begin
                  take      = 1'b1;
                  take_byte = cfg.flag_byte;
               end else if (is_code_esc) begin
                  take      = 1'b1;
                  take_byte = cfg.escape_byte;
               end else begin
                  push              = 1'b1;
                  word.out_kind     = KIND_REPORT;
                  word.frame_status = ST_ABORT;
               end
            end
            default: ;
         endcase
      end

      // Deliver the held byte, hold the new one back
      if (take) begin
         data_xor_in   = data_xor_ff ^ take_byte;
         held_byte_in  = take_byte;
         held_valid_in = 1'b1;
         if (held_valid_ff) begin
            push              = 1'b1;
            word.out_kind     = KIND_PAYLOAD;
            word.payload_byte = held_byte_ff;
            if (byte_count_ff != COUNT_MAX) byte_count_in = byte_count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_START;
         frame_seq_ff    <= 1'b0;
         data_xor_ff     <= 8'd0;
         held_valid_ff   <= 1'b0;
         byte_count_ff   <= 16'd0;
         expected_seq_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         frame_seq_ff    <= frame_seq_in;
         data_xor_ff     <= data_xor_in;
         held_valid_ff   <= held_valid_in;
         byte_count_ff   <= byte_count_in;
         expected_seq_ff <= expected_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

`default_nettype wire

@@ rtl/ifrd_skid.sv @@
// Output register with a skid stage between the parser and the result stream
`default_nettype none

module ifrd_skid
   import ifrd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_word_type push_word,
   output logic              in_ready,
   output logic              skid_full,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_word_type      out_word
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         pop;

   assign pop       = out_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign skid_full = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // advance the skid word; no push while it is full
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

`default_nettype wire

@@ sim/frame_receiver_monitor.sv @@
// Watches the frame receiver channels, predicts each result word and compares it
`timescale 1ns / 100ps

module frame_receiver_monitor
   import ifrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] rx_byte
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] payload_byte, [9:8] frame_status, [11:10] reply_type,
   // [12] reply_seq, [28:13] payload_length, [31:29] zero
   input  wire logic [31:0]           rsp_tdata,
   input  wire logic                  rsp_tuser,   // [0] out_kind
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         mismatches,
   output int                         pending,
   output int                         payload_seen,
   output int                         reports_seen,
   output int                         new_frames
);

   // receiver state as the block should hold it
   logic [7:0]   regs_now [0:6];
   phase_type    rx_phase;
   logic         frame_seq;
   logic         want_seq;
   logic [7:0]   running_xor;
   logic [7:0]   held_byte;
   logic         held_ok;
   logic [15:0]  delivered;
   rsp_word_type awaited_words [$];
   rsp_word_type want;

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] wanted);
      if (got !== wanted)
         flag_error($sformatf("%s: got %0h, expected %0h", name, got, wanted));
   endtask

   // one destuffed data byte: release the held one, hold this one
   task automatic absorb(input logic [7:0] b);
      rsp_word_type w;
      w = '0;
      running_xor = running_xor ^ b;
      if (held_ok) begin
         w.out_kind = KIND_PAYLOAD;
         w.payload_byte = held_byte;
         awaited_words.push_back(w);
         if (delivered != COUNT_MAX)
            delivered = delivered + 16'd1;
      end
      held_byte = b;
      held_ok = 1'b1;
   endtask

   task automatic parse_line_byte(input logic [7:0] b);
      rsp_word_type w;
      logic [7:0]   ctl;
      w = '0;
      w.out_kind = KIND_REPORT;
      case (rx_phase)
         PH_FLAG: begin
            if (b == regs_now[REG_ADDRESS])
               rx_phase = PH_ADDR;
            else if (b != regs_now[REG_FLAG])
               rx_phase = PH_START;
         end
         PH_ADDR: begin
            if (b == regs_now[REG_CTRL0]) begin
               frame_seq = 1'b0;
               rx_phase = PH_CTRL;
            end else if (b == regs_now[REG_CTRL1]) begin
               frame_seq = 1'b1;
               rx_phase = PH_CTRL;
            end else if (b == regs_now[REG_FLAG]) begin
               rx_phase = PH_FLAG;
            end else begin
               rx_phase = PH_START;
            end
         end
         PH_CTRL: begin
            ctl = frame_seq ? regs_now[REG_CTRL1] : regs_now[REG_CTRL0];
            if (b == (regs_now[REG_ADDRESS] ^ ctl)) begin
               rx_phase = PH_DATA;
               running_xor = '0;
               held_byte = '0;
               held_ok = 1'b0;
               delivered = '0;
            end else if (b == regs_now[REG_FLAG]) begin
               rx_phase = PH_FLAG;
            end else begin
               rx_phase = PH_START;
            end
         end
         PH_DATA: begin
            if (b == regs_now[REG_FLAG]) begin
               rx_phase = PH_START;
               // an empty data field counts as a check error
               if (delivered == 16'd0 || running_xor != 8'd0) begin
                  w.frame_status = ST_CHECK_ERR;
                  w.reply_type = RP_REJ;
                  w.reply_seq = frame_seq;
               end else if (frame_seq == want_seq) begin
                  want_seq = ~want_seq;
                  w.frame_status = ST_NEW;
                  w.reply_type = RP_RR;
                  w.reply_seq = ~frame_seq;
                  w.payload_length = delivered;
               end else begin
                  w.frame_status = ST_DUPLICATE;
                  w.reply_type = RP_RR;
                  w.reply_seq = ~frame_seq;
               end
               awaited_words.push_back(w);
            end else if (b == regs_now[REG_ESCAPE]) begin
               rx_phase = PH_ESC;
            end else begin
               absorb(b);
            end
         end
         PH_ESC: begin
            rx_phase = PH_DATA;
            if (b == regs_now[REG_ESC_FLAG]) begin
               absorb(regs_now[REG_FLAG]);
            end else if (b == regs_now[REG_ESC_ESC]) begin
               absorb(regs_now[REG_ESCAPE]);
            end else begin
               // unknown code after escape: abort the frame
               rx_phase = PH_START;
               w.frame_status = ST_ABORT;
               awaited_words.push_back(w);
            end
         end
         default: begin
            rx_phase = (b == regs_now[REG_FLAG]) ? PH_FLAG : PH_START;
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs_now[REG_FLAG] = FLAG_RESET;
         regs_now[REG_ESCAPE] = ESCAPE_RESET;
         regs_now[REG_ESC_FLAG] = ESC_FLAG_RESET;
         regs_now[REG_ESC_ESC] = ESC_ESC_RESET;
         regs_now[REG_ADDRESS] = ADDRESS_RESET;
         regs_now[REG_CTRL0] = CTRL0_RESET;
         regs_now[REG_CTRL1] = CTRL1_RESET;
         rx_phase = PH_START;
         frame_seq = 1'b0;
         want_seq = 1'b0;
         running_xor = '0;
         held_byte = '0;
         held_ok = 1'b0;
         delivered = '0;
         awaited_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_words.size() == 0) begin
               flag_error($sformatf("word with nothing awaited: tdata %h tuser %b",
                                    rsp_tdata, rsp_tuser));
            end else begin
               want = awaited_words.pop_front();
               check_field("out_kind", 16'(rsp_tuser), 16'(want.out_kind));
               check_field("payload_byte", 16'(rsp_tdata[7:0]), 16'(want.payload_byte));
               check_field("frame_status", 16'(rsp_tdata[9:8]), 16'(want.frame_status));
               check_field("reply_type", 16'(rsp_tdata[11:10]), 16'(want.reply_type));
               check_field("reply_seq", 16'(rsp_tdata[12]), 16'(want.reply_seq));
               check_field("payload_length", rsp_tdata[28:13], want.payload_length);
               check_field("tdata padding", 16'(rsp_tdata[31:29]), 16'd0);
               if (want.out_kind == KIND_PAYLOAD) begin
                  payload_seen++;
               end else begin
                  reports_seen++;
                  if (want.frame_status == ST_NEW)
                     new_frames++;
               end
            end
         end
         // the step at this edge still sees the old register values
         if (req_tvalid && req_tready)
            parse_line_byte(req_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] < 7)
            regs_now[csr_paddr[CSR_ADDR_W-1:2]] = csr_pwdata[7:0];
      end
      pending = awaited_words.size();
   end

endmodule

@@ sim/testbench.sv @@
// Stimulus and verdict for the byte-stuffed information frame receiver
`timescale 1ns / 100ps

module testbench;
   import ifrd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef enum {
      FR_GOOD,
      FR_BAD_CHECK,
      FR_BAD_ESCAPE,
      FR_EMPTY,
      FR_BROKEN_HEADER
   } frame_shape_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int pending;
   int payload_seen;
   int reports_seen;
   int new_frames;

   int         cycles;
   int         words_sent;
   int         hold_asked;
   int         hold_done;
   bit         offering;
   bit         sender_lazy;
   bit         rsp_lazy;
   logic       tx_seq;
   logic [7:0] cur_cfg [0:6];

   info_frame_receiver_destuff uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_receiver_monitor watch (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .pending      (pending),
      .payload_seen (payload_seen),
      .reports_seen (reports_seen),
      .new_frames   (new_frames)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // one line byte per word; valid stays up when the next word follows at once
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_lazy ? $urandom_range(0, 17) : 0;
      if (gap > 0 && offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
      repeat (gap) @(posedge clock);
      if (!offering) begin
         req_tvalid <= 1'b1;
         offering = 1'b1;
      end
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic release_line();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // hold the sender until every awaited word has come back
   task automatic drain();
      release_line();
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [7:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_cfg[idx] = val;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [7:0] f, e, cf, ce, a, c0, c1);
      csr_write(REG_FLAG, f);
      csr_write(REG_ESCAPE, e);
      csr_write(REG_ESC_FLAG, cf);
      csr_write(REG_ESC_ESC, ce);
      csr_write(REG_ADDRESS, a);
      csr_write(REG_CTRL0, c0);
      csr_write(REG_CTRL1, c1);
   endtask

   // random setting that still lets well-formed frames through
   task automatic write_usable_random();
      logic [7:0] f, e, cf, ce, a, c0, c1;
      f = 8'($urandom);
      do e = 8'($urandom); while (e == f);
      cf = 8'($urandom);
      do ce = 8'($urandom); while (ce == cf);
      do a = 8'($urandom); while (a == f);
      c0 = 8'($urandom);
      do c1 = 8'($urandom); while (c1 == c0);
      write_all(f, e, cf, ce, a, c0, c1);
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 7))
         0: return cur_cfg[REG_FLAG];
         1: return cur_cfg[REG_ESCAPE];
         2: return cur_cfg[REG_ESC_FLAG];
         3: return cur_cfg[REG_ESC_ESC];
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_data_byte(input logic [7:0] b);
      if (b == cur_cfg[REG_FLAG]) begin
         send_byte(cur_cfg[REG_ESCAPE]);
         send_byte(cur_cfg[REG_ESC_FLAG]);
      end else if (b == cur_cfg[REG_ESCAPE]) begin
         send_byte(cur_cfg[REG_ESCAPE]);
         send_byte(cur_cfg[REG_ESC_ESC]);
      end else begin
         send_byte(b);
      end
   endtask

   task automatic send_frame(input frame_shape_type shape, input int len,
                             input logic seq);
      logic [7:0] ctl, hdr, sum, b, bad;
      int         i, bad_at, cut;
      ctl = seq ? cur_cfg[REG_CTRL1] : cur_cfg[REG_CTRL0];
      hdr = cur_cfg[REG_ADDRESS] ^ ctl;
      sum = '0;
      bad_at = $urandom_range(0, len);
      send_byte(cur_cfg[REG_FLAG]);
      if ($urandom_range(0, 4) == 0)
         send_byte(cur_cfg[REG_FLAG]);
      if (shape == FR_BROKEN_HEADER) begin
         cut = $urandom_range(0, 2);
         if (cut > 0)
            send_byte(cur_cfg[REG_ADDRESS]);
         if (cut > 1)
            send_byte(ctl);
         send_byte(8'($urandom));
         return;
      end
      send_byte(cur_cfg[REG_ADDRESS]);
      send_byte(ctl);
      send_byte(hdr);
      for (i = 0; i <= len; i++) begin
         if (shape == FR_BAD_ESCAPE && i == bad_at) begin
            do bad = 8'($urandom);
            while (bad == cur_cfg[REG_ESC_FLAG] || bad == cur_cfg[REG_ESC_ESC]);
            send_byte(cur_cfg[REG_ESCAPE]);
            send_byte(bad);
            return;
         end
         if (i < len) begin
            b = pick_payload();
            sum = sum ^ b;
            send_data_byte(b);
         end
      end
      if (shape == FR_BAD_CHECK)
         sum = sum ^ 8'($urandom_range(1, 255));
      // an empty frame goes out with or without its check byte
      if (shape != FR_EMPTY || $urandom_range(0, 1) == 1)
         send_data_byte(sum);
      send_byte(cur_cfg[REG_FLAG]);
   endtask

   task automatic run_frames(input int goal);
      int   roll, len;
      logic seq;
      while (words_sent < goal) begin
         roll = $urandom_range(0, 99);
         sender_lazy = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         seq = ($urandom_range(0, 99) < 85) ? tx_seq : ~tx_seq;
         if (roll < 55) begin
            send_frame(FR_GOOD, len, seq);
            if (seq == tx_seq)
               tx_seq = ~tx_seq;
         end else if (roll < 67) begin
            send_frame(FR_BAD_CHECK, len, seq);
         end else if (roll < 75) begin
            send_frame(FR_BAD_ESCAPE, len, seq);
         end else if (roll < 82) begin
            send_frame(FR_EMPTY, 0, seq);
         end else if (roll < 90) begin
            send_frame(FR_BROKEN_HEADER, len, seq);
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(($urandom_range(0, 3) == 0) ? cur_cfg[REG_FLAG] : 8'($urandom));
         end
         if ($urandom_range(0, 24) == 0)
            drain();
      end
   endtask

   // result side: random stalls, a long hold-off on request
   initial begin : rsp_side
      int stall;
      int taken;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 40 == 0)
            rsp_lazy = ($urandom_range(0, 2) != 0);
         if (hold_done != hold_asked) begin
            stall = 300;
            hold_done++;
         end else begin
            stall = rsp_lazy ? $urandom_range(0, 17) : 0;
         end
         if (stall > 0 && rsp_tready)
            rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
         if (!rsp_tready)
            rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : line_side
      logic [7:0] opening [$];
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      reset <= 1'b1;
      cur_cfg[REG_FLAG] = FLAG_RESET;
      cur_cfg[REG_ESCAPE] = ESCAPE_RESET;
      cur_cfg[REG_ESC_FLAG] = ESC_FLAG_RESET;
      cur_cfg[REG_ESC_ESC] = ESC_ESC_RESET;
      cur_cfg[REG_ADDRESS] = ADDRESS_RESET;
      cur_cfg[REG_CTRL0] = CTRL0_RESET;
      cur_cfg[REG_CTRL1] = CTRL1_RESET;
      tx_seq = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset setting: stuffed flag and extreme payload bytes, a duplicate
      // carrying a stuffed escape, then an empty data field
      opening = '{FLAG_RESET, ADDRESS_RESET, CTRL0_RESET, ADDRESS_RESET ^ CTRL0_RESET,
                  ESCAPE_RESET, ESC_FLAG_RESET, 8'hFF, 8'h00, FLAG_RESET ^ 8'hFF,
                  FLAG_RESET,
                  FLAG_RESET, ADDRESS_RESET, CTRL0_RESET, ADDRESS_RESET ^ CTRL0_RESET,
                  ESCAPE_RESET, ESC_ESC_RESET, ESCAPE_RESET, ESC_ESC_RESET, FLAG_RESET,
                  FLAG_RESET, ADDRESS_RESET, CTRL1_RESET, ADDRESS_RESET ^ CTRL1_RESET,
                  FLAG_RESET};
      sender_lazy = 1'b1;
      foreach (opening[i])
         send_byte(opening[i]);
      tx_seq = 1'b1;
      run_frames(120);

      settle();
      write_usable_random();
      run_frames(220);

      // stall the result side while the line keeps offering bytes
      drain();
      hold_asked++;
      sender_lazy = 1'b0;
      send_frame(FR_GOOD, 30, tx_seq);
      tx_seq = ~tx_seq;

      settle();
      write_all(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
      run_frames(320);

      settle();
      write_all(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
      run_frames(420);

      // any values at all, collisions between registers included
      settle();
      write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom));
      run_frames(490);

      settle();
      write_all(FLAG_RESET, ESCAPE_RESET, ESC_FLAG_RESET, ESC_ESC_RESET,
                ADDRESS_RESET, CTRL0_RESET, CTRL1_RESET);
      run_frames(550);

      settle();
      repeat (8) @(posedge clock);

      $display("Sent %0d line bytes under six register settings with stalls on both sides;",
               words_sent);
      $display("  checked %0d payload words, %0d reports (%0d new)",
               payload_seen, reports_seen, new_frames);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
